>>> rtl/scatr_pkg.sv
package scatr_pkg;

  // Default of the ATR length parameter
  localparam int unsigned AtrMaxLenDef = 33;

  // Input modes
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_BYTE    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // Reported status
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COLLECT = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_TS   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Initial characters
  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  // One input request
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  // One result
  typedef struct packed {
    logic [3:0] hist_count;
    logic [5:0] atr_length;
    logic [3:0] protocol;
    logic [5:0] byte_index;
    logic [7:0] stored_byte;
    logic [1:0] error_code;
    logic [1:0] status;
    logic       stored_valid;
  } result_t;

endpackage

>>> rtl/smart_card_atr_parser.sv
// Smart-card Answer To Reset parser.
// Input channel in_*: one request per received event. in_tuser carries the
// mode (start a new ATR, received byte, byte timeout); in_tdata carries the
// received character, used only for a received byte.
// Output channel out_*: exactly one result per request, in order. out_tuser
// flags that the request stored a byte; out_tdata reports status, error code,
// the echoed byte and its index, protocol, ATR length and historical count.
// The accepted request sits in the input register while one pass of the
// parser logic computes the result, which is loaded into the result register
// once that register is free or being taken.
// Throughput: one request per cycle while the receiver does not stall, set by
// a single pass through the state update.
// When the receiver stalls, the result register holds and one more request
// is still taken into the input register; in_tready drops only when both
// registers are full.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// in idle with all counts, masks and the error code cleared.
module smart_card_atr_parser
  import scatr_pkg::*;
#(
  parameter int unsigned ATR_MAX_LEN = AtrMaxLenDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] status, [3:2] error_code, [11:4] stored_byte,
                                  // [17:12] byte_index, [21:18] protocol,
                                  // [27:22] atr_length, [31:28] hist_count
  output logic        out_tuser   // [0] stored_valid
);

  logic    in_v_r;
  item_t   in_item_r;
  logic    out_v_r;
  result_t res_r;
  result_t res_nxt;
  logic    adv;

  // Move the pipeline when the result register is free or being taken
  assign adv       = !out_v_r || out_tready;
  assign in_tready = !in_v_r || adv;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.mode    <= in_tuser;
      in_item_r.rx_byte <= in_tdata;
    end
  end

  scatr_step #(
    .ATR_MAX_LEN(ATR_MAX_LEN)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(adv && in_v_r),
    .item   (in_item_r),
    .result (res_nxt)
  );

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.stored_valid;
  assign out_tdata  = {res_r.hist_count, res_r.atr_length, res_r.protocol,
                       res_r.byte_index, res_r.stored_byte, res_r.error_code,
                       res_r.status};

endmodule

>>> rtl/scatr_step.sv
module scatr_step
  import scatr_pkg::*;
#(
  parameter int unsigned ATR_MAX_LEN = AtrMaxLenDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t result
);

  localparam int unsigned CntW = $clog2(ATR_MAX_LEN + 1);

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TS    = 3'd1;
  localparam logic [2:0] PH_T0    = 3'd2;
  localparam logic [2:0] PH_IFACE = 3'd3;
  localparam logic [2:0] PH_HIST  = 3'd4;
  localparam logic [2:0] PH_TCK   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_ERR   = 3'd7;

  logic [2:0]      phase_r, phase_nxt;
  logic [3:0]      mask_r, mask_nxt;
  logic [3:0]      hist_rem_r, hist_rem_nxt;
  logic [3:0]      hist_tot_r, hist_tot_nxt;
  logic [3:0]      proto_r, proto_nxt;
  logic            td_seen_r, td_seen_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [1:0]      err_r, err_nxt;
  logic            collecting;
  logic            stored;
  logic [6:0]      count_ext;

  // Pick the phase after a byte from what is still expected
  function automatic logic [2:0] next_phase(input logic [3:0] mask, input logic [3:0] hist,
                                            input logic td, input logic [3:0] proto);
    logic [2:0] ph;
    if (mask != 4'd0) begin
      ph = PH_IFACE;
    end else if (hist != 4'd0) begin
      ph = PH_HIST;
    end else if (td && proto != 4'd0) begin
      ph = PH_TCK;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  // Next state for one request
  always_comb begin
    phase_nxt    = phase_r;
    mask_nxt     = mask_r;
    hist_rem_nxt = hist_rem_r;
    hist_tot_nxt = hist_tot_r;
    proto_nxt    = proto_r;
    td_seen_nxt  = td_seen_r;
    count_nxt    = count_r;
    err_nxt      = err_r;
    stored       = 1'b0;
    collecting   = (phase_r >= PH_TS) && (phase_r <= PH_TCK);

    if (item.mode == MODE_START) begin
      phase_nxt    = PH_TS;
      mask_nxt     = 4'd0;
      hist_rem_nxt = 4'd0;
      hist_tot_nxt = 4'd0;
      proto_nxt    = 4'd0;
      td_seen_nxt  = 1'b0;
      count_nxt    = '0;
      err_nxt      = ERR_NONE;
    end else if (item.mode == MODE_TIMEOUT) begin
      if (collecting) begin
        phase_nxt = PH_ERR;
        err_nxt   = ERR_TIMEOUT;
      end
    end else if (item.mode == MODE_BYTE && collecting) begin
      if (phase_r == PH_TS && item.rx_byte != TS_DIRECT && item.rx_byte != TS_INVERSE) begin
        phase_nxt = PH_ERR;
        err_nxt   = ERR_BAD_TS;
      end else if (count_r >= CntW'(ATR_MAX_LEN)) begin
        phase_nxt = PH_ERR;
        err_nxt   = ERR_OVERFLOW;
      end else begin
        stored    = 1'b1;
        count_nxt = count_r + 1'b1;
        case (phase_r)
          PH_TS: begin
            phase_nxt = PH_T0;
          end
          PH_T0: begin
            hist_tot_nxt = item.rx_byte[3:0];
            hist_rem_nxt = item.rx_byte[3:0];
            mask_nxt     = item.rx_byte[7:4];
            phase_nxt    = next_phase(item.rx_byte[7:4], item.rx_byte[3:0],
                                      td_seen_r, proto_r);
          end
          PH_IFACE: begin
            // Take interface bytes in TA, TB, TC, TD order
            if (mask_r[0]) begin
              mask_nxt = {mask_r[3:1], 1'b0};
            end else if (mask_r[1]) begin
              mask_nxt = {mask_r[3:2], 2'b00};
            end else if (mask_r[2]) begin
              mask_nxt = {mask_r[3], 3'b000};
            end else begin
              td_seen_nxt = 1'b1;
              proto_nxt   = item.rx_byte[3:0];
              mask_nxt    = item.rx_byte[7:4];
            end
            phase_nxt = next_phase(mask_nxt, hist_rem_r, td_seen_nxt, proto_nxt);
          end
          PH_HIST: begin
            if (hist_rem_r != 4'd0) begin
              hist_rem_nxt = hist_rem_r - 4'd1;
            end
            phase_nxt = next_phase(mask_r, hist_rem_nxt, td_seen_r, proto_r);
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  // Report the state after this request
  always_comb begin
    count_ext           = 7'(count_nxt);
    result.stored_valid = stored;
    result.stored_byte  = stored ? item.rx_byte : 8'd0;
    result.byte_index   = stored ? 6'(count_r) : 6'd0;
    result.error_code   = err_nxt;
    result.protocol     = td_seen_nxt ? proto_nxt : 4'd0;
    result.atr_length   = (count_ext > 7'd63) ? 6'd63 : count_ext[5:0];
    result.hist_count   = hist_tot_nxt;
    case (phase_nxt)
      PH_IDLE: result.status = ST_IDLE;
      PH_DONE: result.status = ST_DONE;
      PH_ERR:  result.status = ST_ERROR;
      default: result.status = ST_COLLECT;
    endcase
  end

  // Commit the state when the request moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      mask_r     <= 4'd0;
      hist_rem_r <= 4'd0;
      hist_tot_r <= 4'd0;
      proto_r    <= 4'd0;
      td_seen_r  <= 1'b0;
      count_r    <= '0;
      err_r      <= ERR_NONE;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      mask_r     <= mask_nxt;
      hist_rem_r <= hist_rem_nxt;
      hist_tot_r <= hist_tot_nxt;
      proto_r    <= proto_nxt;
      td_seen_r  <= td_seen_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

>>> rtl/scatr_checker.sv
module scatr_checker
  import scatr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("request changed while waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No stored byte means zero echo fields
  a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[17:4] == 14'd0)
    else $error("echo fields set without a stored byte");

  // An error code goes with error status and back
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[3:2] != ERR_NONE) == (out_tdata[1:0] == ST_ERROR)))
    else $error("error code and status disagree");

  // A stored byte leaves the parser collecting or complete
  a_store_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == ST_COLLECT || out_tdata[1:0] == ST_DONE)
    else $error("byte stored in idle or error state");

endmodule

bind smart_card_atr_parser scatr_checker u_scatr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import scatr_pkg::*;

  localparam int unsigned AtrMaxLen = AtrMaxLenDef;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;

  // Predicts the parser result for every accepted request and checks results
  class atr_scoreboard;
    typedef enum logic [2:0] {
      PH_IDLE, PH_TS, PH_T0, PH_IFACE, PH_HIST, PH_TCK, PH_DONE, PH_ERR
    } parse_phase_e;

    parse_phase_e phase;
    logic [3:0]   pending_mask;
    logic [3:0]   hist_left;
    logic [3:0]   hist_total;
    logic [3:0]   last_proto;
    bit           td_seen;
    int unsigned  byte_count;
    logic [1:0]   err_code;
    result_t      expected_q[$];
    int unsigned  effective_requests;
    int unsigned  failures;

    function new();
      clear();
      effective_requests = 0;
      failures = 0;
    endfunction

    function void clear();
      phase = PH_IDLE;
      pending_mask = '0;
      hist_left = '0;
      hist_total = '0;
      last_proto = '0;
      td_seen = 1'b0;
      byte_count = 0;
      err_code = ERR_NONE;
    endfunction

    // Pick the next phase from what is still owed
    function void next_phase();
      if (pending_mask != 0) phase = PH_IFACE;
      else if (hist_left != 0) phase = PH_HIST;
      else if (td_seen && last_proto != 0) phase = PH_TCK;
      else phase = PH_DONE;
    endfunction

    function void note_request(logic [1:0] mode, logic [7:0] b);
      result_t r;
      bit collecting;
      collecting = (phase >= PH_TS) && (phase <= PH_TCK);
      r = '0;
      if (mode == MODE_START || (collecting && (mode == MODE_BYTE || mode == MODE_TIMEOUT)))
        effective_requests++;
      if (mode == MODE_START) begin
        clear();
        phase = PH_TS;
      end else if (mode == MODE_TIMEOUT) begin
        if (collecting) begin
          phase = PH_ERR;
          err_code = ERR_TIMEOUT;
        end
      end else if (mode == MODE_BYTE && collecting) begin
        if (phase == PH_TS && b != TS_DIRECT && b != TS_INVERSE) begin
          phase = PH_ERR;
          err_code = ERR_BAD_TS;
        end else if (byte_count >= AtrMaxLen) begin
          phase = PH_ERR;
          err_code = ERR_OVERFLOW;
        end else begin
          r.stored_valid = 1'b1;
          r.stored_byte = b;
          r.byte_index = byte_count[5:0];
          byte_count++;
          case (phase)
            PH_TS: phase = PH_T0;
            PH_T0: begin
              hist_total = b[3:0];
              hist_left = b[3:0];
              pending_mask = b[7:4];
              next_phase();
            end
            PH_IFACE: begin
              // Interface bytes come in TA, TB, TC, TD order
              if (pending_mask[0]) pending_mask[0] = 1'b0;
              else if (pending_mask[1]) pending_mask[1] = 1'b0;
              else if (pending_mask[2]) pending_mask[2] = 1'b0;
              else begin
                td_seen = 1'b1;
                last_proto = b[3:0];
                pending_mask = b[7:4];
              end
              next_phase();
            end
            PH_HIST: begin
              if (hist_left != 0) hist_left--;
              next_phase();
            end
            default: phase = PH_DONE;
          endcase
        end
      end
      case (phase)
        PH_IDLE: r.status = ST_IDLE;
        PH_DONE: r.status = ST_DONE;
        PH_ERR:  r.status = ST_ERROR;
        default: r.status = ST_COLLECT;
      endcase
      r.error_code = err_code;
      r.protocol = td_seen ? last_proto : 4'd0;
      r.atr_length = (byte_count > 63) ? 6'd63 : byte_count[5:0];
      r.hist_count = hist_total;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
        failures++;
      end
    endfunction

    function void check_result(logic [31:0] data, logic user);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual tdata=%h tuser=%b",
                 $time, data, user);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", 32'(exp_r.status), 32'(data[1:0]));
      compare_field("error_code", 32'(exp_r.error_code), 32'(data[3:2]));
      compare_field("stored_byte", 32'(exp_r.stored_byte), 32'(data[11:4]));
      compare_field("byte_index", 32'(exp_r.byte_index), 32'(data[17:12]));
      compare_field("protocol", 32'(exp_r.protocol), 32'(data[21:18]));
      compare_field("atr_length", 32'(exp_r.atr_length), 32'(data[27:22]));
      compare_field("hist_count", 32'(exp_r.hist_count), 32'(data[31:28]));
      compare_field("stored_valid", 32'(exp_r.stored_valid), 32'(user));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [1:0] status, [3:2] error_code, [11:4] stored_byte,
                                // [17:12] byte_index, [21:18] protocol,
                                // [27:22] atr_length, [31:28] hist_count
  logic        out_tuser;       // [0] stored_valid

  atr_scoreboard sb = new();
  int unsigned   in_idle_pct = 0;
  int unsigned   out_idle_pct = 0;
  bit            hold_off_req = 1'b0;
  int unsigned   hold_count = 0;
  int unsigned   cycle_count = 0;
  logic [7:0]    atr_bytes[$];

  smart_card_atr_parser #(
    .ATR_MAX_LEN(AtrMaxLen)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both channels and feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_off_req && hold_count < HoldCycles) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Offer one request and hold it until it is taken
  task automatic send_request(input logic [1:0] mode, input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Build a well-formed ATR; a long chain keeps TD bytes coming past the limit
  function automatic void build_atr(bit long_chain);
    logic [7:0] t0;
    logic [7:0] td;
    logic [3:0] mask;
    int         depth;
    bit         has_td;
    atr_bytes.delete();
    atr_bytes.push_back($urandom_range(1) ? TS_DIRECT : TS_INVERSE);
    t0 = 8'($urandom_range(255));
    if (long_chain) t0[7:4] = 4'hF;
    atr_bytes.push_back(t0);
    mask = t0[7:4];
    depth = 0;
    has_td = 1'b0;
    td = '0;
    while (mask != 0) begin
      if (mask[0]) atr_bytes.push_back(8'($urandom_range(255)));
      if (mask[1]) atr_bytes.push_back(8'($urandom_range(255)));
      if (mask[2]) atr_bytes.push_back(8'($urandom_range(255)));
      if (mask[3]) begin
        td = 8'($urandom_range(255));
        depth++;
        if (long_chain) td[7:4] = (atr_bytes.size() < 36) ? 4'hF : 4'h0;
        else if (depth >= 3) td[7:4] = 4'h0;
        atr_bytes.push_back(td);
        has_td = 1'b1;
        mask = td[7:4];
      end else begin
        mask = '0;
      end
    end
    repeat (t0[3:0]) atr_bytes.push_back(8'($urandom_range(255)));
    if (has_td && td[3:0] != 0) atr_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // One random sequence: mostly complete ATRs, some broken ones and noise
  task automatic run_sequence();
    int unsigned kind;
    int unsigned cut;
    int unsigned i;
    kind = $urandom_range(99);
    if (kind >= 92) begin
      repeat ($urandom_range(4, 1))
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    build_atr(kind >= 88);
    cut = atr_bytes.size();
    if (kind >= 82 && kind < 88) begin
      atr_bytes[0] = 8'($urandom_range(255));
      cut = $urandom_range(3, 1);
    end else if (kind >= 70 && kind < 82) begin
      cut = $urandom_range(atr_bytes.size() - 1, 1);
    end
    send_request(MODE_START, 8'($urandom_range(255)));
    for (i = 0; i < cut; i++) send_request(MODE_BYTE, atr_bytes[i]);
    if (kind >= 70 && kind < 78)
      send_request(MODE_TIMEOUT, 8'($urandom_range(255)));
    else if (kind < 70 && $urandom_range(4) == 0)
      send_request($urandom_range(1) ? MODE_BYTE : MODE_TIMEOUT, 8'($urandom_range(255)));
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 29;
    out_idle_pct = 67;

    // Requests while idle are ignored
    send_request(MODE_BYTE, TS_DIRECT);
    send_request(MODE_TIMEOUT, 8'h00);
    send_request(MODE_UNUSED, 8'hFF);
    // Bad initial character, then a byte in error
    send_request(MODE_START, 8'h00);
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_BYTE, TS_DIRECT);
    // Full ATR with all interface bytes, two TDs, history and check byte
    send_request(MODE_START, 8'hFF);
    send_request(MODE_BYTE, TS_INVERSE);
    send_request(MODE_BYTE, 8'hF2);
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_BYTE, 8'hFF);
    send_request(MODE_BYTE, 8'h55);
    send_request(MODE_BYTE, 8'h81);
    send_request(MODE_BYTE, 8'h01);
    send_request(MODE_BYTE, 8'hAA);
    send_request(MODE_BYTE, 8'h55);
    send_request(MODE_BYTE, 8'hFF);
    // Complete: timeout and byte are ignored
    send_request(MODE_TIMEOUT, 8'hFF);
    send_request(MODE_BYTE, 8'h3B);
    // Minimal ATR without TD, protocol stays zero
    send_request(MODE_START, 8'h00);
    send_request(MODE_BYTE, TS_DIRECT);
    send_request(MODE_BYTE, 8'h00);
    // Timeout while collecting, restart mid-ATR
    send_request(MODE_START, 8'h00);
    send_request(MODE_BYTE, TS_DIRECT);
    send_request(MODE_TIMEOUT, 8'h00);
    send_request(MODE_START, 8'h00);
    send_request(MODE_BYTE, TS_INVERSE);
    send_request(MODE_START, 8'h00);

    // Random part in three idling regimes
    while (sb.effective_requests < 170) run_sequence();
    in_idle_pct = 67;
    out_idle_pct = 29;
    while (sb.effective_requests < 340) run_sequence();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_off_req = 1'b1;
    while (sb.effective_requests < 500) run_sequence();

    // Drain outstanding results, then watch for strays
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
